// File: hw/rtl/dcp_pkg.sv
// ----------------------------------------------------------------------------
// dcp_pkg: shared types, constants and step functions of the DIMACS parser
// Holds the parser mode encoding, the result record and the per-byte
// next-state functions used by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package dcp_pkg;

	// Width of the value field of a result
	localparam int ValueW = 31;
	// Depth of the result queue
	localparam int FifoDepth = 4;

	localparam logic [7:0] ChNul     = 8'h00;
	localparam logic [7:0] ChNewline = 8'h0A;
	localparam logic [7:0] ChSpace   = 8'h20;
	localparam logic [7:0] ChMinus   = 8'h2D;
	localparam logic [7:0] ChPlus    = 8'h2B;
	localparam logic [7:0] ChZero    = 8'h30;
	localparam logic [7:0] ChNine    = 8'h39;
	localparam logic [7:0] ChLowC    = 8'h63;
	localparam logic [7:0] ChLowF    = 8'h66;
	localparam logic [7:0] ChLowN    = 8'h6E;
	localparam logic [7:0] ChLowP    = 8'h70;
	localparam logic [7:0] ChLowX    = 8'h78;
	localparam logic [7:0] ChTab     = 8'h09;
	localparam logic [7:0] ChCr      = 8'h0D;

	typedef enum logic [2:0] {
		K_LIT   = 3'd0,
		K_CEND  = 3'd1,
		K_HVARS = 3'd2,
		K_HCLS  = 3'd3,
		K_ERR   = 3'd4,
		K_END   = 3'd5
	} kind_t;

	// Parser mode: one-hot. Number contexts have three phases each:
	// 0 before the number, 1 after a sign, 2 inside the digits.
	typedef enum logic [13:0] {
		M_TOP      = 14'b00000000000001,
		M_COMMENT  = 14'b00000000000010,
		M_HDR_SP   = 14'b00000000000100,
		M_HDR_SEL  = 14'b00000000001000,
		M_HDR_TAIL = 14'b00000000010000,
		M_VARS0    = 14'b00000000100000,
		M_VARS1    = 14'b00000001000000,
		M_VARS2    = 14'b00000010000000,
		M_CLS0     = 14'b00000100000000,
		M_CLS1     = 14'b00001000000000,
		M_CLS2     = 14'b00010000000000,
		M_LIT0     = 14'b00100000000000,
		M_LIT1     = 14'b01000000000000,
		M_LIT2     = 14'b10000000000000
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [2:0]         kpos;
		logic [ValueW-1:0]  accum;
		logic               neg;
		logic               xcl;
		logic               xhd;
	} pstate_t;

	typedef struct packed {
		kind_t              kind;
		logic [ValueW-1:0]  value;
		logic               negated;
		logic               xor_clause;
		logic               xor_header;
		logic [7:0]         bad_byte;
		logic               last;
	} res_t;

	// Outcome of one pass of a byte through the parser
	typedef struct packed {
		pstate_t st;
		logic    err;
		logic    has_res;
		res_t    res;
		logic    again;
	} step_t;

	// Results handed from the core to the result queue in the same cycle
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic pstate_t reset_state();
		pstate_t s;
		s       = '0;
		s.mode  = M_TOP;
		return s;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return ((b >= ChTab) && (b <= ChCr)) || (b == ChSpace);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= ChZero) && (b <= ChNine);
	endfunction

	function automatic logic is_phase2(input mode_t m);
		return (m == M_VARS2) || (m == M_CLS2) || (m == M_LIT2);
	endfunction

	// Expected byte of the header keyword tail ("nf" or "cnf")
	function automatic logic [7:0] tail_char(input logic xhd, input logic [2:0] kpos);
		logic [7:0] c;
		c = ChLowF;
		if (xhd) begin
			if (kpos == 3'd0) c = ChLowC;
			else if (kpos == 3'd1) c = ChLowN;
		end else begin
			if (kpos == 3'd0) c = ChLowN;
		end
		return c;
	endfunction

	function automatic mode_t to_phase1(input mode_t m);
		mode_t r;
		unique case (m) inside
			M_VARS0, M_VARS1, M_VARS2: r = M_VARS1;
			M_CLS0, M_CLS1, M_CLS2:    r = M_CLS1;
			default:                   r = M_LIT1;
		endcase
		return r;
	endfunction

	function automatic mode_t to_phase2(input mode_t m);
		mode_t r;
		unique case (m) inside
			M_VARS0, M_VARS1, M_VARS2: r = M_VARS2;
			M_CLS0, M_CLS1, M_CLS2:    r = M_CLS2;
			default:                   r = M_LIT2;
		endcase
		return r;
	endfunction

	function automatic res_t make_res(input kind_t k, input logic [ValueW-1:0] v,
		input logic neg, input pstate_t st, input logic [7:0] bad);
		res_t r;
		r.kind       = k;
		r.value      = v;
		r.negated    = neg;
		r.xor_clause = st.xcl;
		r.xor_header = st.xhd;
		r.bad_byte   = bad;
		r.last       = 1'b0;
		return r;
	endfunction

	// Latch an error on byte b, state otherwise unchanged
	function automatic step_t fail(input pstate_t st, input logic [7:0] b);
		step_t f;
		f.st      = st;
		f.err     = 1'b1;
		f.has_res = 1'b1;
		f.res     = make_res(K_ERR, '0, 1'b0, st, b);
		f.again   = 1'b0;
		return f;
	endfunction

	// Close the pending number and emit its result
	function automatic step_t finish(input pstate_t st);
		step_t f;
		f.st      = st;
		f.err     = 1'b0;
		f.has_res = 1'b1;
		f.again   = 1'b1;
		unique case (st.mode) inside
			M_LIT0, M_LIT1, M_LIT2: begin
				if (st.accum == '0) begin
					f.res     = make_res(K_CEND, '0, 1'b0, st, ChNul);
					f.st.xcl  = 1'b0;
					f.st.mode = M_TOP;
				end else begin
					f.res     = make_res(K_LIT, st.accum - 1'b1, st.neg, st, ChNul);
					f.st.mode = M_LIT0;
				end
			end
			M_VARS0, M_VARS1, M_VARS2: begin
				f.res     = make_res(K_HVARS, st.accum, 1'b0, st, ChNul);
				f.st.mode = M_CLS0;
			end
			default: begin
				f.res     = make_res(K_HCLS, st.accum, 1'b0, st, ChNul);
				f.st.mode = M_TOP;
			end
		endcase
		f.st.accum = '0;
		f.st.neg   = 1'b0;
		return f;
	endfunction

	// One pass of byte b through the parser. acc_next and ovf carry the
	// precomputed times-ten accumulate for the digits phase.
	function automatic step_t feed(input pstate_t st, input logic [7:0] b,
		input logic [ValueW-1:0] acc_next, input logic ovf);
		step_t      f;
		logic [2:0] len;
		logic [2:0] kp1;
		f.st      = st;
		f.err     = 1'b0;
		f.has_res = 1'b0;
		f.res     = '0;
		f.again   = 1'b0;
		len       = st.xhd ? 3'd3 : 3'd2;
		kp1       = st.kpos + 3'd1;
		unique case (st.mode) inside
			M_TOP: begin
				if (!is_space(b)) begin
					if (b == ChLowC) begin
						f.st.mode = M_COMMENT;
					end else if (b == ChLowP) begin
						f.st.mode = M_HDR_SP;
					end else if (b == ChLowX) begin
						f.st.xcl  = 1'b1;
						f.st.mode = M_LIT0;
					end else begin
						f.st.xcl  = 1'b0;
						f.st.mode = M_LIT0;
						f.again   = 1'b1;
					end
				end
			end
			M_COMMENT: begin
				if (b == ChNewline) begin
					f.st.mode = M_TOP;
				end else if (b == ChNul) begin
					f.st.mode = M_TOP;
					f.again   = 1'b1;
				end
			end
			M_HDR_SP: begin
				if (b == ChSpace) f.st.mode = M_HDR_SEL;
				else f = fail(st, b);
			end
			M_HDR_SEL: begin
				if ((b == ChLowC) || (b == ChLowX)) begin
					f.st.xhd  = (b == ChLowX);
					f.st.kpos = 3'd0;
					f.st.mode = M_HDR_TAIL;
				end else begin
					f = fail(st, b);
				end
			end
			M_HDR_TAIL: begin
				if ((st.kpos < len) && (b == tail_char(st.xhd, st.kpos))) begin
					f.st.kpos = kp1;
					if (kp1 >= len) begin
						f.st.kpos = 3'd0;
						f.st.mode = M_VARS0;
					end
				end else begin
					f = fail(st, b);
				end
			end
			M_VARS0, M_CLS0, M_LIT0: begin
				if (!is_space(b)) begin
					if ((b == ChMinus) && (st.mode == M_LIT0)) begin
						f.st.neg   = 1'b1;
						f.st.accum = '0;
						f.st.mode  = to_phase1(st.mode);
					end else if (b == ChPlus) begin
						f.st.neg   = 1'b0;
						f.st.accum = '0;
						f.st.mode  = to_phase1(st.mode);
					end else if (is_digit(b)) begin
						f.st.neg   = 1'b0;
						f.st.accum = ValueW'(b[3:0]);
						f.st.mode  = to_phase2(st.mode);
					end else begin
						f = fail(st, b);
					end
				end
			end
			M_VARS1, M_CLS1, M_LIT1: begin
				if (is_digit(b)) begin
					f.st.accum = ValueW'(b[3:0]);
					f.st.mode  = to_phase2(st.mode);
				end else begin
					f = fail(st, b);
				end
			end
			M_VARS2, M_CLS2, M_LIT2: begin
				if (is_digit(b)) begin
					if (ovf) f = fail(st, b);
					else f.st.accum = acc_next;
				end else begin
					f = finish(st);
				end
			end
			default: begin
				f.st.mode = M_TOP;
			end
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dcp_channel_if.sv
// ----------------------------------------------------------------------------
// dcp_channel_if: valid/ready channels of the DIMACS parser
// Input channel carries one text byte or the end marker; output channel
// carries one parse result.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_input;

	modport source (output valid, output char_byte, output end_of_input, input ready);
	modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface dcp_out_if;
	logic                       valid;
	logic                       ready;
	dcp_pkg::kind_t             kind;
	logic [dcp_pkg::ValueW-1:0] value;
	logic                       negated;
	logic                       xor_clause;
	logic                       xor_header;
	logic [7:0]                 bad_byte;
	logic                       last;

	modport source (output valid, output kind, output value, output negated,
		output xor_clause, output xor_header, output bad_byte, output last,
		input ready);
	modport sink   (input valid, input kind, input value, input negated,
		input xor_clause, input xor_header, input bad_byte, input last,
		output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dcp_core.sv
// ----------------------------------------------------------------------------
// dcp_core: input register, parser state and per-byte step logic
// Registers a byte, steps the parser on it (twice if it ends a number,
// opens a clause or is NUL in a comment) and hands up to two results on.
// ----------------------------------------------------------------------------
`default_nettype none

module dcp_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	dcp_in_if.sink          text,
	input  wire logic       room,
	output dcp_pkg::push_t  push
);

	localparam int AccW  = VALUE_WIDTH - 1;
	localparam int ProdW = VALUE_WIDTH + 3;
	localparam int ValW  = dcp_pkg::ValueW;
	localparam logic [ProdW-1:0] MagLimit = ProdW'((64'd1 << AccW) - 64'd1);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eoi_s1;
	dcp_pkg::pstate_t state_q;
	logic             err_q;

	logic             fire;
	logic [ProdW-1:0] prod;
	logic             ovf;
	logic [ValW-1:0]  acc_next;
	dcp_pkg::step_t   f1;
	dcp_pkg::step_t   f2;
	dcp_pkg::step_t   fe;
	dcp_pkg::pstate_t st_e;
	dcp_pkg::res_t    r_end;
	dcp_pkg::pstate_t st_next;
	logic             err_next;
	dcp_pkg::push_t   push_c;

	// Take a new byte whenever the register drains this cycle
	assign fire       = valid_s1 && room;
	assign text.ready = !valid_s1 || room;

	// Times-ten accumulate and range check for the digits phase
	assign prod     = ProdW'({state_q.accum[AccW-1:0], 3'b000})
		+ ProdW'({state_q.accum[AccW-1:0], 1'b0}) + ProdW'(byte_s1[3:0]);
	assign ovf      = prod > MagLimit;
	assign acc_next = ValW'(prod[AccW-1:0]);

	// Step the parser over the held byte
	always_comb begin
		f1       = dcp_pkg::feed(state_q, byte_s1, acc_next, ovf);
		f2       = dcp_pkg::feed(f1.st, byte_s1, acc_next, ovf);
		fe       = dcp_pkg::finish(state_q);
		st_e     = state_q;
		r_end    = '0;
		push_c   = '0;
		st_next  = state_q;
		err_next = err_q;
		if (eoi_s1) begin
			st_next  = dcp_pkg::reset_state();
			err_next = 1'b0;
			if (err_q) begin
				push_c.n  = 2'd1;
				push_c.r0 = dcp_pkg::make_res(dcp_pkg::K_END, '0, 1'b0, state_q,
					dcp_pkg::ChNul);
			end else begin
				if (dcp_pkg::is_phase2(state_q.mode)) begin
					st_e = fe.st;
				end
				if ((st_e.mode == dcp_pkg::M_TOP) || (st_e.mode == dcp_pkg::M_COMMENT)) begin
					r_end = dcp_pkg::make_res(dcp_pkg::K_END, '0, 1'b0, st_e, dcp_pkg::ChNul);
				end else begin
					r_end = dcp_pkg::make_res(dcp_pkg::K_ERR, '0, 1'b0, st_e, dcp_pkg::ChNul);
				end
				if (dcp_pkg::is_phase2(state_q.mode)) begin
					push_c.n  = 2'd2;
					push_c.r0 = fe.res;
					push_c.r1 = r_end;
				end else begin
					push_c.n  = 2'd1;
					push_c.r0 = r_end;
				end
			end
		end else if (!err_q) begin
			if (f1.again) begin
				st_next  = f2.st;
				err_next = f2.err;
				if (f1.has_res && f2.has_res) begin
					push_c.n  = 2'd2;
					push_c.r0 = f1.res;
					push_c.r1 = f2.res;
				end else if (f1.has_res) begin
					push_c.n  = 2'd1;
					push_c.r0 = f1.res;
				end else if (f2.has_res) begin
					push_c.n  = 2'd1;
					push_c.r0 = f2.res;
				end
			end else begin
				st_next  = f1.st;
				err_next = f1.err;
				if (f1.has_res) begin
					push_c.n  = 2'd1;
					push_c.r0 = f1.res;
				end
			end
		end
		// Mark the final result of this byte
		if (push_c.n == 2'd1) push_c.r0.last = 1'b1;
		if (push_c.n == 2'd2) push_c.r1.last = 1'b1;
		// Hand results on only when the byte retires
		if (!fire) push_c.n = 2'd0;
	end

	assign push = push_c;

	// Control: input valid, parser state, error latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= dcp_pkg::reset_state();
			err_q    <= 1'b0;
		end else begin
			if (text.ready) valid_s1 <= text.valid;
			if (fire) begin
				state_q <= st_next;
				err_q   <= err_next;
			end
		end
	end

	// Payload: hold the accepted byte
	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.char_byte;
			eoi_s1  <= text.end_of_input;
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> room)
		else $error("results pushed without queue space");

	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && err_q && !eoi_s1) |-> (push.n == 2'd0))
		else $error("result produced after a latched error");

	a_eoi_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && eoi_s1) |=> (!err_q && (state_q.mode == dcp_pkg::M_TOP)))
		else $error("end of input did not return parser to reset state");

endmodule

`default_nettype wire

// File: hw/rtl/dcp_res_fifo.sv
// ----------------------------------------------------------------------------
// dcp_res_fifo: result queue of the DIMACS parser
// Takes up to two results per cycle and presents one per output transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module dcp_res_fifo (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  dcp_pkg::push_t  push,
	output logic            room,
	dcp_out_if.source       result
);

	localparam int Depth = dcp_pkg::FifoDepth;
	localparam int PtrW  = $clog2(Depth);
	localparam int CntW  = $clog2(Depth + 1);

	logic [CntW-1:0] count_q;
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	dcp_pkg::res_t   mem_q [Depth];
	dcp_pkg::res_t   head;
	logic            pop;

	// Space for a byte that yields two results
	assign room = count_q <= CntW'(Depth - 2);
	assign pop  = result.valid && result.ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wr_q    <= '0;
			rd_q    <= '0;
		end else begin
			count_q <= count_q + CntW'(push.n) - CntW'(pop);
			wr_q    <= wr_q + PtrW'(push.n);
			rd_q    <= rd_q + PtrW'(pop);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem_q[wr_q] <= push.r0;
		if (push.n == 2'd2) mem_q[wr_q + PtrW'(1)] <= push.r1;
	end

	// Present the head entry
	assign head              = mem_q[rd_q];
	assign result.valid      = count_q != '0;
	assign result.kind       = head.kind;
	assign result.value      = head.value;
	assign result.negated    = head.negated;
	assign result.xor_clause = head.xor_clause;
	assign result.xor_header = head.xor_header;
	assign result.bad_byte   = head.bad_byte;
	assign result.last       = head.last;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> ((int'(count_q) + int'(push.n)) <= Depth))
		else $error("result queue overflow");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == CntW'($past(count_q) + CntW'($past(push.n))
			- CntW'($past(pop)))))
		else $error("result queue count out of step");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(PtrW'(wr_q - rd_q) == PtrW'(count_q)))
		else $error("result queue pointers disagree with fill count");

endmodule

`default_nettype wire

// File: hw/rtl/dimacs_cnf_stream_parser.sv
// ----------------------------------------------------------------------------
// dimacs_cnf_stream_parser: DIMACS CNF/XCNF text to literal stream
// Parses one text byte per input transaction into header counts, literals,
// clause ends, errors and an end-of-stream marker.
// ----------------------------------------------------------------------------
// The parser accepts one byte per clock cycle while the result queue has room.
// A byte is held in the input register until it retires; its results are then
// written into the result queue, whose head is presented on the output.
// A byte yields zero, one or two results; two come
// when the byte ends a number and also produces a result of its own, or at
// end of input when a pending number is closed ahead of the end or error
// result. Such a byte needs two output transactions, so the input side
// follows the output rate. A four-entry result queue sits between the step
// logic and the output channel; a byte is taken from the input register
// only while the queue has space for two results, so the output ready has
// no combinational path to the input ready. After an error the parser
// stays silent until end of input, which returns it to its reset state.
`default_nettype none

module dimacs_cnf_stream_parser #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dcp_in_if.sink     text,
	dcp_out_if.source  result
);

	dcp_pkg::push_t push;
	logic           room;

	// Byte register and parser state
	dcp_core #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.room   (room),
		.push   (push)
	);

	// Result queue
	dcp_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.result (result)
	);

endmodule

`default_nettype wire

// File: tb/dimacs_cnf_stream_parser_test.sv
// ----------------------------------------------------------------------------
// dimacs_cnf_stream_parser_test: self-checking bench of the DIMACS parser
// Streams DIMACS text through the input channel, one byte per transaction,
// predicts every result with an independent parser model and compares each
// result transaction against the oldest prediction. Both channel sides idle
// at random, and the result side holds off for long stretches.
// ----------------------------------------------------------------------------
`default_nettype none

module dimacs_cnf_stream_parser_test;
	import dcp_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int DrainCycles = 20;
	localparam int HoldCycles = 64;
	localparam int StreamItems = 1450;
	localparam longint unsigned MagMax = 64'd2147483647;

	typedef struct packed {
		logic [7:0] ch;
		logic       eoi;
	} text_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       in_eoi = 1'b0;
	logic       out_ready = 1'b0;

	dcp_in_if  text_if ();
	dcp_out_if result_if ();

	assign text_if.valid        = in_valid;
	assign text_if.char_byte    = in_byte;
	assign text_if.end_of_input = in_eoi;
	assign result_if.ready      = out_ready;

	dimacs_cnf_stream_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.result (result_if)
	);

	// Clock: 12 units per period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	text_item_t pending_bytes[$];
	res_t       due_results[$];
	res_t       seen;
	int         stim_total = 0;
	int         bytes_taken = 0;
	int         results_taken = 0;
	int         mismatches = 0;
	int         cycle_count = 0;
	int         hold_left = 0;
	int         holds_done = 0;

	assign seen = {result_if.kind, result_if.value, result_if.negated, result_if.xor_clause,
		result_if.xor_header, result_if.bad_byte, result_if.last};

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------
	mode_t       pmode = M_TOP;
	logic [2:0]  kpos = '0;
	logic [31:0] acc = '0;
	logic        neg = 1'b0;
	logic        xcl = 1'b0;
	logic        xhd = 1'b0;
	logic        err_seen = 1'b0;

	function automatic void clear_parser();
		pmode    = M_TOP;
		kpos     = '0;
		acc      = '0;
		neg      = 1'b0;
		xcl      = 1'b0;
		xhd      = 1'b0;
		err_seen = 1'b0;
	endfunction

	function automatic bit blank_char(input logic [7:0] b);
		return (b >= ChTab && b <= ChCr) || b == ChSpace;
	endfunction

	function automatic bit digit_char(input logic [7:0] b);
		return b >= ChZero && b <= ChNine;
	endfunction

	// Move a number context to the sign phase (1) or the digits phase (2)
	function automatic mode_t with_phase(input mode_t m, input int ph);
		if (m inside {M_VARS0, M_VARS1, M_VARS2}) return (ph == 1) ? M_VARS1 : M_VARS2;
		if (m inside {M_CLS0, M_CLS1, M_CLS2}) return (ph == 1) ? M_CLS1 : M_CLS2;
		return (ph == 1) ? M_LIT1 : M_LIT2;
	endfunction

	function automatic void emit_result(input kind_t k, input logic [ValueW-1:0] v,
		input logic ng, input logic [7:0] bad);
		res_t r;
		r.kind       = k;
		r.value      = v;
		r.negated    = ng;
		r.xor_clause = xcl;
		r.xor_header = xhd;
		r.bad_byte   = bad;
		r.last       = 1'b0;
		due_results.push_back(r);
	endfunction

	function automatic void latch_error(input logic [7:0] b);
		emit_result(K_ERR, '0, 1'b0, b);
		err_seen = 1'b1;
	endfunction

	// Close the number in the digits phase and report it
	function automatic void close_number();
		if (pmode == M_LIT2) begin
			if (acc == '0) begin
				emit_result(K_CEND, '0, 1'b0, ChNul);
				xcl   = 1'b0;
				pmode = M_TOP;
			end else begin
				emit_result(K_LIT, ValueW'(acc - 32'd1), neg, ChNul);
				pmode = M_LIT0;
			end
		end else if (pmode == M_VARS2) begin
			emit_result(K_HVARS, ValueW'(acc), 1'b0, ChNul);
			pmode = M_CLS0;
		end else begin
			emit_result(K_HCLS, ValueW'(acc), 1'b0, ChNul);
			pmode = M_TOP;
		end
		acc = '0;
		neg = 1'b0;
	endfunction

	// One pass of a byte; returns 1 when the byte must be seen again
	function automatic bit scan_byte(input logic [7:0] b);
		logic [63:0] grown;
		logic [7:0]  tail_want;
		logic [2:0]  kw_len;
		bit          again;
		again = 1'b0;
		if (xhd) tail_want = (kpos == 3'd0) ? ChLowC : (kpos == 3'd1) ? ChLowN : ChLowF;
		else tail_want = (kpos == 3'd0) ? ChLowN : ChLowF;
		kw_len = xhd ? 3'd3 : 3'd2;
		case (pmode)
			M_TOP: begin
				if (!blank_char(b)) begin
					if (b == ChLowC) begin
						pmode = M_COMMENT;
					end else if (b == ChLowP) begin
						pmode = M_HDR_SP;
					end else if (b == ChLowX) begin
						xcl   = 1'b1;
						pmode = M_LIT0;
					end else begin
						xcl   = 1'b0;
						pmode = M_LIT0;
						again = 1'b1;
					end
				end
			end
			M_COMMENT: begin
				if (b == ChNewline) begin
					pmode = M_TOP;
				end else if (b == ChNul) begin
					pmode = M_TOP;
					again = 1'b1;
				end
			end
			M_HDR_SP: begin
				if (b == ChSpace) pmode = M_HDR_SEL;
				else latch_error(b);
			end
			M_HDR_SEL: begin
				if (b == ChLowC || b == ChLowX) begin
					xhd   = (b == ChLowX);
					kpos  = '0;
					pmode = M_HDR_TAIL;
				end else begin
					latch_error(b);
				end
			end
			M_HDR_TAIL: begin
				if (kpos < kw_len && b == tail_want) begin
					kpos = kpos + 3'd1;
					if (kpos >= kw_len) begin
						kpos  = '0;
						pmode = M_VARS0;
					end
				end else begin
					latch_error(b);
				end
			end
			M_VARS0, M_CLS0, M_LIT0: begin
				if (!blank_char(b)) begin
					if (b == ChMinus && pmode == M_LIT0) begin
						neg   = 1'b1;
						acc   = '0;
						pmode = with_phase(pmode, 1);
					end else if (b == ChPlus) begin
						neg   = 1'b0;
						acc   = '0;
						pmode = with_phase(pmode, 1);
					end else if (digit_char(b)) begin
						neg   = 1'b0;
						acc   = 32'(b - ChZero);
						pmode = with_phase(pmode, 2);
					end else begin
						latch_error(b);
					end
				end
			end
			M_VARS1, M_CLS1, M_LIT1: begin
				if (digit_char(b)) begin
					acc   = 32'(b - ChZero);
					pmode = with_phase(pmode, 2);
				end else begin
					latch_error(b);
				end
			end
			M_VARS2, M_CLS2, M_LIT2: begin
				if (digit_char(b)) begin
					grown = 64'(acc) * 64'd10 + 64'(b - ChZero);
					if (grown > MagMax) latch_error(b);
					else acc = grown[31:0];
				end else begin
					close_number();
					again = 1'b1;
				end
			end
		endcase
		return again;
	endfunction

	// Predict the results of one accepted input transaction
	function automatic void take_byte(input logic [7:0] b, input logic eoi);
		int   first;
		bit   again;
		res_t tail;
		first = due_results.size();
		if (eoi) begin
			if (err_seen) begin
				emit_result(K_END, '0, 1'b0, ChNul);
			end else begin
				if (pmode inside {M_VARS2, M_CLS2, M_LIT2}) close_number();
				if (pmode == M_TOP || pmode == M_COMMENT) emit_result(K_END, '0, 1'b0, ChNul);
				else latch_error(ChNul);
			end
			clear_parser();
		end else if (!err_seen) begin
			again = scan_byte(b);
			if (again && !err_seen) void'(scan_byte(b));
		end
		// Mark the final result of this transaction
		if (due_results.size() > first) begin
			tail      = due_results.pop_back();
			tail.last = 1'b1;
			due_results.push_back(tail);
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	function automatic void add_item(input logic [7:0] b, input logic eoi);
		text_item_t t;
		t.ch  = b;
		t.eoi = eoi;
		pending_bytes.push_back(t);
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		add_item(b, 1'b0);
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endfunction

	function automatic void add_blank();
		case ($urandom_range(9))
			0: add_byte(ChTab);
			1: add_byte(ChNewline);
			2: add_byte(8'h0B);
			3: add_byte(8'h0C);
			4: add_byte(ChCr);
			default: add_byte(ChSpace);
		endcase
	endfunction

	// Mostly small magnitudes; now and then the limit, just past it, or huge
	function automatic longint unsigned pick_mag(input int lo);
		case ($urandom_range(49))
			0: return MagMax;
			1: return MagMax + 64'd1;
			2: return 64'($urandom);
			3: return 64'd9999999999;
			default: return 64'($urandom_range(30, lo));
		endcase
	endfunction

	function automatic void add_number(input longint unsigned m, input bit hdr);
		int r;
		r = $urandom_range(99);
		if (hdr) begin
			if (r < 3) add_byte(ChMinus);
			else if (r < 12) add_byte(ChPlus);
		end else begin
			if (r < 45) add_byte(ChMinus);
			else if (r < 55) add_byte(ChPlus);
		end
		if ($urandom_range(99) < 5) add_byte(ChZero);
		add_text($sformatf("%0d", m));
	endfunction

	function automatic void add_comment();
		int n;
		add_byte(ChLowC);
		n = $urandom_range(8);
		repeat (n) add_byte(8'($urandom_range(126, 32)));
		if ($urandom_range(9) == 0) add_byte(ChNul);
		else add_byte(ChNewline);
	endfunction

	function automatic void add_header();
		add_text("p ");
		if ($urandom_range(1)) add_text("xcnf");
		else add_text("cnf");
		add_blank();
		add_number(pick_mag(0), 1'b1);
		add_blank();
		add_number(pick_mag(0), 1'b1);
	endfunction

	// Header cut short or bent, then an arbitrary byte
	function automatic void add_broken_header();
		case ($urandom_range(5))
			0: add_text("p");
			1: add_text("p  cnf");
			2: add_text("p cn");
			3: add_text("p xc");
			4: add_text("p xcnf");
			default: add_text("p cnf 3 ");
		endcase
		add_byte(8'($urandom_range(255)));
	endfunction

	function automatic void add_clause(input bit closed);
		int n;
		int r;
		if ($urandom_range(99) < 30) begin
			add_byte(ChLowX);
			if ($urandom_range(1)) add_blank();
		end
		n = $urandom_range(4);
		repeat (n) begin
			add_number(pick_mag(1), 1'b0);
			if ($urandom_range(99) < 85) add_blank();
		end
		if (closed) begin
			r = $urandom_range(99);
			if (r < 10) add_byte(ChMinus);
			else if (r < 20) add_byte(ChPlus);
			add_byte(ChZero);
		end
	endfunction

	// One stream: optional comment and header, clauses, end marker
	function automatic void add_stream();
		int  r;
		int  n;
		bit  closed;
		r = $urandom_range(99);
		if (r < 25) add_comment();
		r = $urandom_range(99);
		if (r < 65) begin
			add_header();
			add_blank();
		end else if (r < 75) begin
			add_broken_header();
		end
		n = $urandom_range(6);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 8) add_comment();
			else if (r < 11) add_byte(8'($urandom_range(255)));
			closed = ($urandom_range(99) >= 6);
			add_clause(closed);
			if (!closed) break;
			if (i < n - 1 || $urandom_range(1)) add_blank();
		end
		if ($urandom_range(19) == 0) add_text("c A");
		add_item(8'($urandom_range(255)), 1'b1);
	endfunction

	// ------------------------------------------------------------------
	// Input driver
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte  <= 8'h00;
			in_eoi   <= 1'b0;
			clear_parser();
		end else begin
			// Predict on each accepted transaction
			if (in_valid && text_if.ready) begin
				take_byte(in_byte, in_eoi);
				bytes_taken++;
				void'(pending_bytes.pop_front());
			end
			// Offer the next byte, or idle; hold while stalled
			if (!in_valid || text_if.ready) begin
				if (pending_bytes.size() > 0 && $urandom_range(99) >=
						((bytes_taken < stim_total / 3) ? 31 :
						(bytes_taken < 2 * stim_total / 3) ? 52 : 0)) begin
					in_valid <= 1'b1;
					in_byte  <= pending_bytes[0].ch;
					in_eoi   <= pending_bytes[0].eoi;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	function automatic string res_text(input res_t r);
		return $sformatf("kind=%0d value=%0d neg=%0b xc=%0b xh=%0b bad=%02h last=%0b",
			r.kind, r.value, r.negated, r.xor_clause, r.xor_header, r.bad_byte, r.last);
	endfunction

	// ------------------------------------------------------------------
	// Result monitor and checker
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : result_check
		res_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (result_if.valid && out_ready) begin
				results_taken++;
				if (due_results.size() == 0) begin
					$display("%0t  unexpected result: expected none, actual %s", $time,
						res_text(seen));
					mismatches++;
				end else begin
					want = due_results.pop_front();
					if (seen !== want) begin
						$display("%0t  result mismatch: expected %s, actual %s", $time,
							res_text(want), res_text(seen));
						mismatches++;
					end
				end
			end
			// Long hold-offs let the block fill up and stall its input
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if ((holds_done == 0 && results_taken >= 100) ||
					(holds_done == 1 && bytes_taken >= stim_total * 5 / 6)) begin
				holds_done++;
				hold_left = HoldCycles;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >=
					((bytes_taken < stim_total / 3) ? 52 :
					(bytes_taken < 2 * stim_total / 3) ? 31 : 0));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CycleLimit) begin
			$display("[dimacs_cnf_stream_parser] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence: directed text, random streams, reset, drain, verdict
	// ------------------------------------------------------------------
	initial begin
		// x header, x clause, number ended by a sign, "-0" close, end after a number
		add_text("p xcnf 2 1\nx1-2 -0");
		add_item(8'hA5, 1'b1);
		// NUL ends a comment and leaves an open clause
		add_byte(ChLowC);
		add_byte(ChNul);
		add_item(8'h5A, 1'b1);
		stim_total = pending_bytes.size() + StreamItems;
		while (pending_bytes.size() < stim_total) add_stream();
		stim_total = pending_bytes.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_bytes.size() > 0 || in_valid) @(posedge clk);
		while (due_results.size() > 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0) begin
			$display("[dimacs_cnf_stream_parser] OK");
		end else begin
			$display("[dimacs_cnf_stream_parser] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
